[sv/assert_macros.svh]
// Assertion macros for the port-level checker of the pixel mapper.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define VAPM_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define VAPM_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

[sv/vapm_pkg.sv]
// Package with the types, codes and constants of the attribute pixel mapper.
`timescale 1ns / 1ps
package vapm_pkg;

   localparam int AttrWidth     = 8;
   localparam int RowWidth      = 5;
   localparam int IndexWidth    = 4;
   localparam int DacWidth      = 8;
   localparam int PixelWidth    = 16;
   localparam int ExtraWidth    = 2;
   localparam int CsrIndexWidth = 4;
   localparam int CsrDataWidth  = 48;
   localparam int EntryWidth    = 6;
   localparam int QueueDepth    = 4;

   // Attribute values with no bits set other than 7 and 3 are blank in mono mode.
   localparam logic [AttrWidth-1:0] MonoBlankMask = 8'h88;
   localparam logic [2:0]           UnderlineAttr = 3'd1;

   typedef enum logic [CsrIndexWidth-1:0] {
      RegModeFlags     = 4'd0,
      RegUnderlineRow  = 4'd1,
      RegPlaneEnable   = 4'd2,
      RegPaletteOn     = 4'd3,
      RegColorSelect   = 4'd4,
      RegPaletteLow    = 4'd5,
      RegPaletteHigh   = 4'd6,
      RegPixelWidth    = 4'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      WidthNibble = 2'd0,
      WidthByte   = 2'd1,
      WidthWord   = 2'd2,
      WidthUnused = 2'd3
   } width_mode_type;

   localparam logic [ExtraWidth-1:0] ExtraNibble = 2'd0;
   localparam logic [ExtraWidth-1:0] ExtraByte   = 2'd1;
   localparam logic [ExtraWidth-1:0] ExtraWord   = 2'd3;

   typedef struct packed {
      logic [3:0]              mode_flags;
      logic [RowWidth-1:0]     underline_row;
      logic [IndexWidth-1:0]   plane_enable;
      logic                    palette_on;
      logic [3:0]              color_select;
      logic [CsrDataWidth-1:0] palette_low;
      logic [CsrDataWidth-1:0] palette_high;
      logic [1:0]              pixel_width_mode;
   } cfg_type;

endpackage

[sv/vapm_channels.sv]
// Handshake channel interfaces for pixel items, results and register writes.
`timescale 1ns / 1ps
interface vapm_req_if import vapm_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic [AttrWidth-1:0] attribute_byte;
   logic                 font_pixel;
   logic                 blink_phase;
   logic [RowWidth-1:0]  char_row;

   modport source(output valid, attribute_byte, font_pixel, blink_phase, char_row,
                  input ready);
   modport sink(input valid, attribute_byte, font_pixel, blink_phase, char_row,
                output ready);
endinterface

interface vapm_rsp_if import vapm_pkg::*;;
   logic                  valid;
   logic                  ready;
   logic [PixelWidth-1:0] pixel_value;
   logic                  pixel_complete;
   logic [ExtraWidth-1:0] extra_clocks;

   modport source(output valid, pixel_value, pixel_complete, extra_clocks, input ready);
   modport sink(input valid, pixel_value, pixel_complete, extra_clocks, output ready);
endinterface

interface vapm_csr_if import vapm_pkg::*;;
   logic                     valid;
   logic                     ready;
   logic [CsrIndexWidth-1:0] index;
   logic [CsrDataWidth-1:0]  data;

   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

[sv/vapm_csr.sv]
// Configuration register file written through the register channel.
`timescale 1ns / 1ps
module vapm_csr import vapm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   vapm_csr_if.sink   csr_ch,
   output cfg_type    cfg
);

   // Everything clears on reset except the plane mask and the palette enable.
   localparam cfg_type CfgReset = '{
      mode_flags:       4'h0,
      underline_row:    '0,
      plane_enable:     '1,
      palette_on:       1'b1,
      color_select:     4'h0,
      palette_low:      '0,
      palette_high:     '0,
      pixel_width_mode: 2'd0
   };

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ch.ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         unique case (csr_index_type'(csr_ch.index))
            RegModeFlags:    cfg_in.mode_flags       = csr_ch.data[3:0];
            RegUnderlineRow: cfg_in.underline_row    = csr_ch.data[RowWidth-1:0];
            RegPlaneEnable:  cfg_in.plane_enable     = csr_ch.data[IndexWidth-1:0];
            RegPaletteOn:    cfg_in.palette_on       = csr_ch.data[0];
            RegColorSelect:  cfg_in.color_select     = csr_ch.data[3:0];
            RegPaletteLow:   cfg_in.palette_low      = csr_ch.data;
            RegPaletteHigh:  cfg_in.palette_high     = csr_ch.data;
            RegPixelWidth:   cfg_in.pixel_width_mode = csr_ch.data[1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CfgReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[sv/vapm_front.sv]
// Front end: accepts pixel transactions and resolves them to a 4-bit color index.
`timescale 1ns / 1ps
module vapm_front import vapm_pkg::*; (
   vapm_req_if.sink               req_ch,
   input  cfg_type                cfg,
   input  logic                   q_full,
   output logic                   q_push,
   output logic [IndexWidth-1:0]  q_index
);

   logic                 blink_en;
   logic                 mono;
   logic                 fg;
   logic [AttrWidth-1:0] attr;
   logic [IndexWidth-1:0] raw_index;

   assign attr     = req_ch.attribute_byte;
   assign blink_en = cfg.mode_flags[1];
   assign mono     = cfg.mode_flags[2];

   assign req_ch.ready = ~q_full;
   assign q_push       = req_ch.valid & ~q_full;

   always_comb begin
      fg = req_ch.font_pixel;
      if (mono) begin
         if ((req_ch.char_row == cfg.underline_row) && (attr[2:0] == UnderlineAttr)) begin
            fg = 1'b1;
         end
         if ((attr & MonoBlankMask) == attr) begin
            fg = 1'b0;
         end
      end
      if (blink_en && attr[7]) begin
         fg = fg & req_ch.blink_phase;
      end
      // With blink on, attribute bit 7 is the blink flag, not a background bit.
      if (fg) begin
         raw_index = attr[IndexWidth-1:0];
      end else begin
         raw_index = {attr[7] & ~blink_en, attr[6:4]};
      end
      q_index = raw_index & cfg.plane_enable;
   end

endmodule

[sv/vapm_fifo.sv]
// Small queue of color indices between the front and back ends.
`timescale 1ns / 1ps
module vapm_fifo import vapm_pkg::*; #(
   parameter int Depth = QueueDepth
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  logic [IndexWidth-1:0] push_data,
   output logic                  full,
   input  logic                  pop,
   output logic                  not_empty,
   output logic [IndexWidth-1:0] pop_data
);

   localparam int PtrWidth   = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CountWidth = $clog2(Depth + 1);
   localparam logic [CountWidth-1:0] CountFull = CountWidth'(Depth);
   localparam logic [PtrWidth-1:0]   PtrLast   = PtrWidth'(Depth - 1);

   logic [IndexWidth-1:0] mem_ff [Depth];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0] count_ff, count_in;

   assign full      = (count_ff == CountFull);
   assign not_empty = (count_ff != '0);
   assign pop_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrLast) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrLast) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[sv/vapm_back.sv]
// Back end: palette lookup, color select, nibble packing and the result register.
`timescale 1ns / 1ps
module vapm_back import vapm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  logic                  q_valid,
   input  logic [IndexWidth-1:0] q_index,
   output logic                  q_pop,
   vapm_rsp_if.source            rsp_ch
);

   localparam int HalfEntries = 8;

   logic                  load;
   logic [EntryWidth-1:0] entry;
   logic [EntryWidth-1:0] entry_sel;
   logic [DacWidth-1:0]   dac;
   logic [3:0]            nib;
   logic [CsrDataWidth-1:0] pal_half;

   logic [7:0]            packed_byte_ff, packed_byte_in;
   logic                  toggle_ff, toggle_in;
   logic [PixelWidth-1:0] packed_word_ff, packed_word_in;
   logic [1:0]            word_count_ff, word_count_in;

   logic                  valid_ff;
   logic [PixelWidth-1:0] value_ff, value_in;
   logic                  complete_ff, complete_in;
   logic [ExtraWidth-1:0] extra_ff, extra_in;

   assign load  = q_valid & (~valid_ff | rsp_ch.ready);
   assign q_pop = load;

   always_comb begin
      pal_half  = q_index[3] ? cfg.palette_high : cfg.palette_low;
      entry     = pal_half[q_index[2:0] * EntryWidth +: EntryWidth];
      entry_sel = cfg.mode_flags[3] ? {cfg.color_select[1:0], entry[3:0]} : entry;
      if (!cfg.palette_on) begin
         dac = {{(DacWidth-IndexWidth){1'b0}}, q_index};
      end else if (cfg.mode_flags[0]) begin
         dac = {4'b0, entry[3:0]};
      end else begin
         dac = {cfg.color_select[3:2], entry_sel};
      end
      nib = dac[3:0];
   end

   always_comb begin
      packed_byte_in = packed_byte_ff;
      toggle_in      = toggle_ff;
      packed_word_in = packed_word_ff;
      word_count_in  = word_count_ff;
      unique case (width_mode_type'(cfg.pixel_width_mode))
         WidthByte: begin
            packed_byte_in = {packed_byte_ff[3:0], nib};
            toggle_in      = ~toggle_ff;
            value_in       = {8'b0, packed_byte_in};
            complete_in    = toggle_ff;
            extra_in       = ExtraByte;
         end
         WidthWord: begin
            packed_word_in = {packed_word_ff[PixelWidth-5:0], nib};
            word_count_in  = word_count_ff + 1'b1;
            value_in       = packed_word_in;
            complete_in    = (word_count_in == 2'd0);
            extra_in       = ExtraWord;
         end
         default: begin
            value_in    = {{(PixelWidth-DacWidth){1'b0}}, dac};
            complete_in = 1'b1;
            extra_in    = ExtraNibble;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (load) begin
         value_ff    <= value_in;
         complete_ff <= complete_in;
         extra_ff    <= extra_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff       <= 1'b0;
         packed_byte_ff <= '0;
         toggle_ff      <= 1'b0;
         packed_word_ff <= '0;
         word_count_ff  <= '0;
      end else begin
         if (load) begin
            valid_ff       <= 1'b1;
            packed_byte_ff <= packed_byte_in;
            toggle_ff      <= toggle_in;
            packed_word_ff <= packed_word_in;
            word_count_ff  <= word_count_in;
         end else if (rsp_ch.ready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_ch.valid          = valid_ff;
   assign rsp_ch.pixel_value    = value_ff;
   assign rsp_ch.pixel_complete = complete_ff;
   assign rsp_ch.extra_clocks   = extra_ff;

   // The palette is split in two halves of this many entries each.
   if (HalfEntries * EntryWidth != CsrDataWidth) begin : g_bad_palette
      $error("palette register width does not hold eight entries");
   end

endmodule

[sv/vga_attribute_pixel_mapper_top.sv]
// Top level: registers, front end, index queue and back end of the pixel mapper.
// A pixel accepted on req_ch is queued, then loaded into the result register for rsp_ch.
// Throughput: one pixel per cycle unless rsp_ch stalls the single-entry result register.
// The queue holds QueueDepth pixels, so req_ch keeps accepting while rsp_ch stalls briefly.
// Reset is synchronous: registers return to their defaults, packing state clears,
// and the queue and result register empty.
`timescale 1ns / 1ps
module vga_attribute_pixel_mapper_top import vapm_pkg::*; #(
   parameter int QUEUE_DEPTH = QueueDepth
) (
   input  logic        clock,
   input  logic        reset,
   vapm_req_if.sink    req_ch,
   vapm_rsp_if.source  rsp_ch,
   vapm_csr_if.sink    csr_ch
);

   cfg_type               cfg;
   logic                  q_push;
   logic                  q_full;
   logic                  q_pop;
   logic                  q_valid;
   logic [IndexWidth-1:0] q_wr_index;
   logic [IndexWidth-1:0] q_rd_index;

   vapm_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   vapm_front u_front (
      .req_ch  (req_ch),
      .cfg     (cfg),
      .q_full  (q_full),
      .q_push  (q_push),
      .q_index (q_wr_index)
   );

   vapm_fifo #(
      .Depth (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wr_index),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_valid),
      .pop_data  (q_rd_index)
   );

   vapm_back u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .q_valid (q_valid),
      .q_index (q_rd_index),
      .q_pop   (q_pop),
      .rsp_ch  (rsp_ch)
   );

endmodule

[sv/vapm_checker.sv]
// Port-level assertions for the pixel mapper and their binding to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module vapm_checker import vapm_pkg::*; #(
   parameter int Depth = QueueDepth
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [PixelWidth-1:0] rsp_pixel_value,
   input logic                  rsp_pixel_complete,
   input logic [ExtraWidth-1:0] rsp_extra_clocks
);

   localparam int PendWidth = $clog2(Depth + 2);
   localparam logic [PendWidth-1:0] PendMax = PendWidth'(Depth + 1);

   logic                 req_fire;
   logic                 rsp_fire;
   logic [PendWidth-1:0] pending_ff, pending_in;

   assign req_fire = req_valid & req_ready;
   assign rsp_fire = rsp_valid & rsp_ready;

   always_comb begin
      pending_in = pending_ff;
      if (req_fire && !rsp_fire) begin
         pending_in = pending_ff + 1'b1;
      end else if (rsp_fire && !req_fire) begin
         pending_in = pending_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // A stalled result transaction keeps its contents.
   `VAPM_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pixel_value) && $stable(rsp_pixel_complete) && $stable(rsp_extra_clocks), "result changed while stalled")

   // Every result stems from an accepted pixel, and no more pixels are in flight than fit.
   `VAPM_ASSERT(a_no_invented, (!rsp_valid || pending_ff != '0) && pending_ff <= PendMax, "result count does not match accepted pixels")

   // Extra clocks are 0, 1 or 3, and single nibble pixels are always complete.
   `VAPM_ASSERT(a_extra_code, rsp_valid |-> (rsp_extra_clocks != 2'd2) && ((rsp_extra_clocks != ExtraNibble) || rsp_pixel_complete), "bad extra clock code")

   // Nothing is offered right after reset.
   `VAPM_ASSERT_ALWAYS(a_reset_empty, $past(reset) |-> !rsp_valid, "result valid after reset")

endmodule

bind vga_attribute_pixel_mapper_top vapm_checker #(
   .Depth (QUEUE_DEPTH)
) u_vapm_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_ch.valid),
   .req_ready          (req_ch.ready),
   .rsp_valid          (rsp_ch.valid),
   .rsp_ready          (rsp_ch.ready),
   .rsp_pixel_value    (rsp_ch.pixel_value),
   .rsp_pixel_complete (rsp_ch.pixel_complete),
   .rsp_extra_clocks   (rsp_ch.extra_clocks)
);
